### hdl/l2s_pkg.sv
// ----------------------------------------------------------------------------
// l2s_pkg: shared constants, types and curve node table
// Fixed-point formats, pipeline depth and the x^(5/12) node table built at
// elaboration for the linear to sRGB encoder.
// ----------------------------------------------------------------------------
package l2s_pkg;

   // Field formats
   localparam int CHAN_W         = 18;
   localparam int BYTE_W         = 8;
   localparam int FRAC_BITS      = 16;
   localparam int CURVE_SEGMENTS = 32;

   // Octaves of the raw input code covered by the curve table
   localparam int E_LO = FRAC_BITS - 9;
   localparam int E_HI = 16;
   localparam int NOCT = E_HI + 1 - E_LO;
   localparam int UX_W = E_HI + 1;

   // Lane pipeline depth; the last stage is the output register
   localparam int NUM_STAGES = 6;

   // Linear branch: 12.92 in Q16, rounding half up
   localparam int LIN_SHIFT  = 16;
   localparam int LIN_PROD_W = CHAN_W + 21;
   localparam int LIN_V_W    = LIN_PROD_W - LIN_SHIFT;
   localparam logic signed [LIN_PROD_W-1:0] LIN_GAIN = LIN_PROD_W'(846725);
   localparam logic signed [LIN_PROD_W-1:0] LIN_HALF = LIN_PROD_W'(32768);

   // Curve branch: 1.055 in Q30 and 0.055 in Q28
   localparam int GAIN_W     = 31;
   localparam int GAIN_SHIFT = 30;
   localparam logic [GAIN_W-1:0] GAIN_Q30 = GAIN_W'(1132797624);
   localparam int OFFSET_Q28 = 14763950;
   localparam int ENC_SH     = 28 - FRAC_BITS;
   localparam int ENC_RND    = 1 << (27 - FRAC_BITS);

   // Saturation bounds of the encoded value
   localparam int ENC_MAX = 131071;
   localparam int ENC_MIN = -131072;
   localparam int CMP_W   = 40;

   // Wide enough to hold a channel and the value one, with a sign bit
   localparam int CLAMP_W = ((FRAC_BITS + 1 > CHAN_W) ? FRAC_BITS + 1 : CHAN_W) + 1;
   localparam logic signed [CLAMP_W-1:0] ONE_CODE = CLAMP_W'(1) << FRAC_BITS;
   // Largest code for which x * 10^7 <= 31308 * 2^FRAC_BITS
   localparam longint THR_VAL = (64'd31308 << FRAC_BITS) / 64'd10000000;
   localparam logic signed [CLAMP_W-1:0] THR_CODE = CLAMP_W'(THR_VAL);

   localparam int BP_W = CLAMP_W + BYTE_W;

   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = v_in;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] icbrt64(input logic [63:0] v);
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      lo = '0;
      hi = (64'd1 << 21) - 64'd1;
      for (int i = 0; i < 22; i++) begin
         if (lo < hi) begin
            mid = (lo + hi + 64'd1) >> 1;
            if (mid * mid * mid <= v) begin
               lo = mid;
            end else begin
               hi = mid - 64'd1;
            end
         end
      end
      return lo;
   endfunction

   // x^(5/12) in Q28 as the product of x^(1/4) and x^(1/6)
   function automatic logic [63:0] curve_node(input logic [63:0] code);
      logic [63:0] w;
      logic [63:0] q4;
      logic [63:0] q6;
      w  = code << (54 - FRAC_BITS);
      q4 = isqrt64(isqrt64(w) << 27);
      q6 = isqrt64(icbrt64(w) << 36);
      return (q4 * q6 + (64'd1 << 25)) >> 26;
   endfunction

   function automatic int calc_seg_bits();
      int k;
      k = 0;
      for (int i = 0; i < 8; i++) begin
         if (k + 1 <= E_LO && (longint'(2) << k) * NOCT <= CURVE_SEGMENTS) begin
            k = k + 1;
         end
      end
      return k;
   endfunction

   localparam int SEG_BITS = calc_seg_bits();
   localparam int NSEG     = 1 << SEG_BITS;
   localparam int S_MAX    = E_HI - SEG_BITS;
   localparam int NNODE    = NOCT * NSEG + 1;
   localparam int IDX_W    = $clog2(NNODE);
   localparam int OCT_W    = $clog2(NOCT);

   localparam logic [63:0] NODE_TOP = curve_node(64'd1 << (E_HI + 1));
   localparam int NODE_W = $clog2(NODE_TOP + 64'd1);
   localparam int YG_W   = GAIN_W + NODE_W - GAIN_SHIFT;
   localparam int V_W    = YG_W + 1 - ENC_SH;

   typedef logic [NODE_W-1:0] node_rom_type [NNODE];

   // Node n sits at octave n / NSEG, segment n % NSEG; the last node closes
   // the top octave, and each octave's end node is the next octave's start.
   function automatic node_rom_type build_node_rom();
      node_rom_type rom;
      int o;
      int j;
      for (int n = 0; n < NNODE; n++) begin
         o = n >> SEG_BITS;
         j = n & (NSEG - 1);
         rom[n] = NODE_W'(curve_node((64'd1 << (E_LO + o)) +
                                     (64'(j) << (E_LO + o - SEG_BITS))));
      end
      return rom;
   endfunction

   localparam node_rom_type NODE_ROM = build_node_rom();

   typedef struct packed {
      logic                  clamp;
      logic [NUM_STAGES-1:0] load;
   } l2s_ctl_type;

endpackage

### hdl/linear_to_srgb_encoder_top.sv
// ----------------------------------------------------------------------------
// linear_to_srgb_encoder_top: sRGB gamma encoder, one pixel per clock
// Three channel lanes run side by side; their output registers together
// form one result item.
//
//   Channel   Ports                           Direction   Handshake
//   --------  ------------------------------  ----------  -----------------
//   request   req_lin_red/green/blue          in          req_valid/stall
//   response  rsp_enc_*, rsp_byte_*           out         rsp_valid/stall
//   csr       csr_wr_data                     in          csr_wr_en
//
// One item per clock sustained while rsp_stall is low. The six lane stages
// are octave search, node lookup, two multiplier stages, saturation and
// byte conversion. Synchronous reset clears all stage valid bits and sets
// the clamp enable. A stalled response holds the output registers while
// empty stages upstream keep filling, so the input stalls only when every
// stage holds an item.
// ----------------------------------------------------------------------------
module linear_to_srgb_encoder_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [l2s_pkg::CHAN_W-1:0]   req_lin_red,
   input  logic signed [l2s_pkg::CHAN_W-1:0]   req_lin_green,
   input  logic signed [l2s_pkg::CHAN_W-1:0]   req_lin_blue,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [l2s_pkg::CHAN_W-1:0]   rsp_enc_red,
   output logic signed [l2s_pkg::CHAN_W-1:0]   rsp_enc_green,
   output logic signed [l2s_pkg::CHAN_W-1:0]   rsp_enc_blue,
   output logic        [l2s_pkg::BYTE_W-1:0]   rsp_byte_red,
   output logic        [l2s_pkg::BYTE_W-1:0]   rsp_byte_green,
   output logic        [l2s_pkg::BYTE_W-1:0]   rsp_byte_blue,
   input  logic                                csr_wr_en,
   input  logic                                csr_wr_data
);
   import l2s_pkg::*;

   l2s_ctl_type ctl;

   l2s_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .ctl         (ctl)
   );

   l2s_lane u_lane_red (
      .clock    (clock),
      .ctl      (ctl),
      .lin      (req_lin_red),
      .enc      (rsp_enc_red),
      .enc_byte (rsp_byte_red)
   );

   l2s_lane u_lane_green (
      .clock    (clock),
      .ctl      (ctl),
      .lin      (req_lin_green),
      .enc      (rsp_enc_green),
      .enc_byte (rsp_byte_green)
   );

   l2s_lane u_lane_blue (
      .clock    (clock),
      .ctl      (ctl),
      .lin      (req_lin_blue),
      .enc      (rsp_enc_blue),
      .enc_byte (rsp_byte_blue)
   );

endmodule

### hdl/l2s_ctrl.sv
// ----------------------------------------------------------------------------
// l2s_ctrl: pipeline flow control and clamp register
// Tracks one valid bit per lane stage, lets bubbles collapse under a stalled
// output, and holds the clamp enable written through the CSR port.
// ----------------------------------------------------------------------------
module l2s_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic                 csr_wr_en,
   input  logic                 csr_wr_data,
   output l2s_pkg::l2s_ctl_type ctl
);
   import l2s_pkg::*;

   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES-1:0] ready;
   logic [NUM_STAGES-1:0] up_vld;
   logic                  clamp_ff;
   logic                  clamp_in;

   // A stage can take a new item when it is empty or its contents move on.
   always_comb begin
      ready[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         ready[k] = !vld_ff[k] || ready[k+1];
      end
   end

   assign up_vld   = {vld_ff[NUM_STAGES-2:0], req_valid};
   assign vld_in   = (ready & up_vld) | (~ready & vld_ff);
   assign clamp_in = csr_wr_en ? csr_wr_data : clamp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         clamp_ff <= 1'b1;
      end else begin
         vld_ff   <= vld_in;
         clamp_ff <= clamp_in;
      end
   end

   assign ctl.load   = ready & up_vld;
   assign ctl.clamp  = clamp_ff;
   assign req_stall  = !ready[0];
   assign rsp_valid  = vld_ff[NUM_STAGES-1];

endmodule

### hdl/l2s_lane.sv
// ----------------------------------------------------------------------------
// l2s_lane: one color channel of the sRGB encoder
// Six-stage datapath: clamp and octave search, node lookup and linear
// product, interpolation, gain, offset and saturation, byte conversion.
// ----------------------------------------------------------------------------
module l2s_lane (
   input  logic                                clock,
   input  l2s_pkg::l2s_ctl_type                ctl,
   input  logic signed [l2s_pkg::CHAN_W-1:0]   lin,
   output logic signed [l2s_pkg::CHAN_W-1:0]   enc,
   output logic        [l2s_pkg::BYTE_W-1:0]   enc_byte
);
   import l2s_pkg::*;

   // Stage 0: clamp, branch decision, leading-one search, normalize
   logic signed [CLAMP_W-1:0] xw;
   logic [UX_W-1:0]           ux;
   logic [UX_W-1:0]           ux_r;
   logic [OCT_W-1:0]          oct;
   logic [OCT_W-1:0]          norm_sh;
   logic                      s0_lin_in,  s0_lin_ff;
   logic signed [CHAN_W-1:0]  s0_x_in,    s0_x_ff;
   logic [OCT_W-1:0]          s0_oct_in,  s0_oct_ff;
   logic [UX_W-1:0]           s0_uxn_in,  s0_uxn_ff;

   always_comb begin
      xw = {{(CLAMP_W - CHAN_W){lin[CHAN_W-1]}}, lin};
      if (ctl.clamp) begin
         if (xw < 0) begin
            xw = '0;
         end else if (xw > ONE_CODE) begin
            xw = ONE_CODE;
         end
      end
      s0_lin_in = (xw <= THR_CODE);
      s0_x_in   = xw[CHAN_W-1:0];
   end

   // The curve branch only sees positive codes, so the low bits are the value.
   always_comb begin
      ux  = s0_x_in[UX_W-1:0];
      oct = '0;
      for (int b = E_LO + 1; b <= E_HI; b++) begin
         if (ux[b]) begin
            oct = OCT_W'(b - E_LO);
         end
      end
      ux_r      = (ux < (UX_W'(1) << E_LO)) ? (UX_W'(1) << E_LO) : ux;
      norm_sh   = OCT_W'(NOCT - 1) - oct;
      s0_oct_in = oct;
      s0_uxn_in = ux_r << norm_sh;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         s0_lin_ff <= s0_lin_in;
         s0_x_ff   <= s0_x_in;
         s0_oct_ff <= s0_oct_in;
         s0_uxn_ff <= s0_uxn_in;
      end
   end

   // Stage 1: node pair lookup and the linear product
   logic [IDX_W-1:0]               idx0;
   logic [IDX_W-1:0]               idx1;
   logic [NODE_W-1:0]              n0;
   logic [NODE_W-1:0]              n1;
   logic signed [LIN_PROD_W-1:0]   lin_prod;
   logic                           s1_lin_in,  s1_lin_ff;
   logic signed [LIN_V_W-1:0]      s1_linv_in, s1_linv_ff;
   logic [NODE_W-1:0]              s1_n0_in,   s1_n0_ff;
   logic [NODE_W-1:0]              s1_diff_in, s1_diff_ff;
   logic [S_MAX-1:0]               s1_r_in,    s1_r_ff;

   // After normalizing, the bits under the leading one give the segment and
   // the remainder, already aligned to the finest octave.
   always_comb begin
      idx0 = IDX_W'((IDX_W'(s0_oct_ff) << SEG_BITS) |
                    (IDX_W'(s0_uxn_ff >> S_MAX) & IDX_W'(NSEG - 1)));
      idx1 = IDX_W'(idx0 + IDX_W'(1));
      n0   = NODE_ROM[idx0];
      n1   = NODE_ROM[idx1];
      s1_n0_in   = n0;
      s1_diff_in = (n1 > n0) ? NODE_W'(n1 - n0) : '0;
      s1_r_in    = s0_uxn_ff[S_MAX-1:0];
      lin_prod   = LIN_PROD_W'(s0_x_ff) * LIN_GAIN + LIN_HALF;
      s1_linv_in = lin_prod[LIN_PROD_W-1:LIN_SHIFT];
      s1_lin_in  = s0_lin_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[1]) begin
         s1_lin_ff  <= s1_lin_in;
         s1_linv_ff <= s1_linv_in;
         s1_n0_ff   <= s1_n0_in;
         s1_diff_ff <= s1_diff_in;
         s1_r_ff    <= s1_r_in;
      end
   end

   // Stage 2: interpolation between the two nodes
   logic [NODE_W+S_MAX-1:0]   ip;
   logic                      s2_lin_in,  s2_lin_ff;
   logic signed [LIN_V_W-1:0] s2_linv_in, s2_linv_ff;
   logic [NODE_W-1:0]         s2_p_in,    s2_p_ff;

   always_comb begin
      ip         = (NODE_W + S_MAX)'(s1_diff_ff) * (NODE_W + S_MAX)'(s1_r_ff);
      s2_p_in    = NODE_W'(s1_n0_ff + ip[NODE_W+S_MAX-1:S_MAX]);
      s2_lin_in  = s1_lin_ff;
      s2_linv_in = s1_linv_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[2]) begin
         s2_lin_ff  <= s2_lin_in;
         s2_linv_ff <= s2_linv_in;
         s2_p_ff    <= s2_p_in;
      end
   end

   // Stage 3: scale by 1.055
   logic [GAIN_W+NODE_W-1:0]  gp;
   logic                      s3_lin_in,  s3_lin_ff;
   logic signed [LIN_V_W-1:0] s3_linv_in, s3_linv_ff;
   logic [YG_W-1:0]           s3_y_in,    s3_y_ff;

   always_comb begin
      gp         = (GAIN_W + NODE_W)'(GAIN_Q30) * (GAIN_W + NODE_W)'(s2_p_ff);
      s3_y_in    = gp[GAIN_W+NODE_W-1:GAIN_SHIFT];
      s3_lin_in  = s2_lin_ff;
      s3_linv_in = s2_linv_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[3]) begin
         s3_lin_ff  <= s3_lin_in;
         s3_linv_ff <= s3_linv_in;
         s3_y_ff    <= s3_y_in;
      end
   end

   // Stage 4: subtract 0.055, round to the output format, saturate
   logic [YG_W-1:0]          ys;
   logic [YG_W:0]            yr;
   logic [V_W-1:0]           vr;
   logic signed [CHAN_W-1:0] s4_enc_in, s4_enc_ff;

   always_comb begin
      ys = (s3_y_ff > YG_W'(OFFSET_Q28)) ? YG_W'(s3_y_ff - YG_W'(OFFSET_Q28)) : '0;
      yr = (YG_W + 1)'(ys) + (YG_W + 1)'(ENC_RND);
      vr = yr[YG_W:ENC_SH];
      if (s3_lin_ff) begin
         if (s3_linv_ff > LIN_V_W'(ENC_MAX)) begin
            s4_enc_in = CHAN_W'(ENC_MAX);
         end else if (s3_linv_ff < LIN_V_W'(ENC_MIN)) begin
            s4_enc_in = CHAN_W'(ENC_MIN);
         end else begin
            s4_enc_in = s3_linv_ff[CHAN_W-1:0];
         end
      end else begin
         if (CMP_W'(vr) > CMP_W'(ENC_MAX)) begin
            s4_enc_in = CHAN_W'(ENC_MAX);
         end else begin
            s4_enc_in = CHAN_W'(vr);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[4]) begin
         s4_enc_ff <= s4_enc_in;
      end
   end

   // Stage 5: unit-range clamp, times 255, truncate; output register
   logic signed [CLAMP_W-1:0] cw;
   logic [BP_W-1:0]           bprod;
   logic signed [CHAN_W-1:0]  out_enc_in,  out_enc_ff;
   logic [BYTE_W-1:0]         out_byte_in, out_byte_ff;

   always_comb begin
      cw = {{(CLAMP_W - CHAN_W){s4_enc_ff[CHAN_W-1]}}, s4_enc_ff};
      if (cw < 0) begin
         cw = '0;
      end else if (cw > ONE_CODE) begin
         cw = ONE_CODE;
      end
      bprod       = (BP_W'(unsigned'(cw)) << BYTE_W) - BP_W'(unsigned'(cw));
      out_byte_in = bprod[FRAC_BITS +: BYTE_W];
      out_enc_in  = s4_enc_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[5]) begin
         out_enc_ff  <= out_enc_in;
         out_byte_ff <= out_byte_in;
      end
   end

   assign enc      = out_enc_ff;
   assign enc_byte = out_byte_ff;

endmodule
